// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the dither row RTL
// Concurrent checks on clk with the synchronous reset rst held off.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/edd_pkg.sv =====
// ----------------------------------------------------------------------------
// edd_pkg
// Types, register indexes and the per-dot error arithmetic of the dither row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package edd_pkg;

  localparam int NUM_LANES = 3;
  localparam int LANE_W    = 8;
  localparam int ERR_W     = NUM_LANES * LANE_W;

  // configuration register indexes
  localparam logic REG_COLOUR_MODE   = 1'b0;
  localparam logic REG_DOT_THRESHOLD = 1'b1;

  localparam logic [7:0] DOT_THRESHOLD_RESET = 8'd127;
  localparam logic signed [10:0] DOT_ON_OFFSET = 11'sd255;
  localparam logic signed [12:0] SPLIT_ROUND  = 13'sd6;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_PIXEL,
    SEQ_FLUSH
  } edd_seq_state_t;

  // one operation handed from the sequencer to the update stage
  typedef struct packed {
    logic                                 flush;  // row end: swap and clear
    logic                                 last;   // final dot of the transaction
    logic                                 colour; // all three lanes active
    logic                                 bank;   // current-row bank
    logic [NUM_LANES-1:0][LANE_W-1:0]     chan;
  } edd_op_t;

  // line buffer write control from the update stage
  typedef struct packed {
    logic nxt_we;   // write of the next-row bank at the op position
    logic clr_we;   // clear of column 0 in the current-row bank
    logic cur_bank;
  } edd_wr_ctl_t;

  typedef struct packed {
    logic              on;
    logic [LANE_W-1:0] e3;
    logic [LANE_W-1:0] e2;
  } edd_px_t;

  // dot decision and error split for one lane
  function automatic edd_px_t edd_diffuse_px(input logic [7:0] src,
                                             input logic [7:0] err,
                                             input logic [7:0] thr);
    logic signed [9:0]  sum;
    logic signed [10:0] x;
    logic signed [12:0] xe;
    logic signed [12:0] t;
    logic signed [12:0] e3;
    logic signed [12:0] e2;
    edd_px_t            r;
    sum  = $signed({{2{err[7]}}, err}) + $signed({2'b00, src});
    r.on = sum > $signed({2'b00, thr});
    if (r.on) begin
      x = $signed({sum[9], sum}) - DOT_ON_OFFSET;
    end else begin
      x = $signed({sum, 1'b0});
    end
    xe   = $signed({{2{x[10]}}, x});
    t    = (xe <<< 1) + xe + SPLIT_ROUND;
    e3   = t >>> 3;
    e2   = xe - (e3 <<< 1);
    r.e3 = e3[7:0];
    r.e2 = e2[7:0];
    return r;
  endfunction

endpackage

// ===== rtl/edd_ram.sv =====
// ----------------------------------------------------------------------------
// edd_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module edd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/edd_seq.sv =====
// ----------------------------------------------------------------------------
// edd_seq
// Input sequencer: takes a source pixel, issues one dot per repeat and a
// flush op at row end; owns the column position and the bank select.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module edd_seq #(
  parameter int MAX_ROW_PIXELS = 4096,
  parameter int MAX_REPEAT     = 16,
  localparam int PW            = $clog2(MAX_ROW_PIXELS + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [31:0]      s_tdata,
  input  logic             s_tlast,
  input  logic             colour_mode,
  input  logic             adv,
  output logic             issue,
  output edd_pkg::edd_op_t op,
  output logic [PW-1:0]    pos
);

  import edd_pkg::*;

  localparam int RW = ($clog2(MAX_REPEAT + 1) > 5) ? $clog2(MAX_REPEAT + 1) : 5;

  edd_seq_state_t                   state, state_next;
  logic [NUM_LANES-1:0][LANE_W-1:0] chan;
  logic                             row_end;
  logic [RW-1:0]                    rem;
  logic                             sel;
  logic [RW-1:0]                    rep;
  logic [RW-1:0]                    rep_sat;

  assign rep     = RW'(s_tdata[28:24]);
  assign rep_sat = (rep == '0) ? RW'(1) :
                   ((rep > RW'(MAX_REPEAT)) ? RW'(MAX_REPEAT) : rep);

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    issue      = 1'b0;
    op.flush   = 1'b0;
    op.last    = (rem == RW'(1));
    op.colour  = colour_mode;
    op.bank    = sel;
    op.chan    = chan;
    case (state)
      SEQ_IDLE: begin
        // held low through reset
        s_tready = !rst;
        if (s_tvalid) begin
          state_next = SEQ_PIXEL;
        end
      end
      SEQ_PIXEL: begin
        if (adv) begin
          issue = 1'b1;
          if (rem == RW'(1)) begin
            state_next = row_end ? SEQ_FLUSH : SEQ_IDLE;
          end
        end
      end
      SEQ_FLUSH: begin
        if (adv) begin
          issue      = 1'b1;
          op.flush   = 1'b1;
          state_next = SEQ_IDLE;
        end
      end
      default: begin
        state_next = SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
      pos <= '0;
      sel <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        rem <= rep_sat;
      end else if (issue && !op.flush) begin
        rem <= rem - RW'(1);
        if (pos < PW'(MAX_ROW_PIXELS)) begin
          pos <= pos + PW'(1);
        end
      end else if (issue && op.flush) begin
        pos <= '0;
        sel <= ~sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      chan[0] <= s_tdata[7:0];
      chan[1] <= s_tdata[15:8];
      chan[2] <= s_tdata[23:16];
      row_end <= s_tlast;
    end
  end

  `ASSERT_NEXT(a_flush_swaps, issue && op.flush, pos == '0 && sel != $past(sel),
               "row end did not rewind the column and swap the banks")

endmodule

// ===== rtl/edd_diffuse.sv =====
// ----------------------------------------------------------------------------
// edd_diffuse
// Update stage: takes the line buffer read data, decides the dots, writes
// the next-row error back and holds the result in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module edd_diffuse #(
  parameter int MAX_ROW_PIXELS = 4096,
  localparam int PW            = $clog2(MAX_ROW_PIXELS + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [7:0]               dot_threshold,
  input  logic                     issue,
  input  edd_pkg::edd_op_t         op_in,
  input  logic [PW-1:0]            pos_in,
  input  logic [edd_pkg::ERR_W-1:0] rd0,
  input  logic [edd_pkg::ERR_W-1:0] rd1,
  output logic                     adv,
  output edd_pkg::edd_wr_ctl_t     wr_ctl,
  output logic [PW-1:0]            wr_addr,
  output logic [edd_pkg::ERR_W-1:0] wr_data,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [7:0]               m_tdata,
  output logic                     m_tlast
);

  import edd_pkg::*;

  logic                             s1_valid;
  edd_op_t                          s1_op;
  logic [PW-1:0]                    s1_pos;
  logic [NUM_LANES-1:0][LANE_W-1:0] carry;
  logic [NUM_LANES-1:0][LANE_W-1:0] pend;
  logic [NUM_LANES-1:0]             pend_v;

  logic                             out_free;
  logic                             fire;
  logic                             sat;
  logic [NUM_LANES-1:0][LANE_W-1:0] cur_w;
  logic [NUM_LANES-1:0][LANE_W-1:0] nxt_w;
  logic [NUM_LANES-1:0][LANE_W-1:0] base;
  logic [NUM_LANES-1:0][LANE_W-1:0] wval;
  logic [NUM_LANES-1:0]             active;
  logic [NUM_LANES-1:0]             dots;
  edd_px_t                          px [NUM_LANES];

  assign out_free = !m_tvalid || m_tready;
  assign fire     = s1_valid && (s1_op.flush || out_free);
  assign adv      = !s1_valid || fire;
  assign sat      = (s1_pos == PW'(MAX_ROW_PIXELS));
  assign cur_w    = s1_op.bank ? rd1 : rd0;
  assign nxt_w    = s1_op.bank ? rd0 : rd1;

  // lanes are independent; pend holds the live next-row byte of this column
  always_comb begin
    for (int c = 0; c < NUM_LANES; c++) begin
      active[c] = (c == 0) || s1_op.colour;
      px[c]     = edd_diffuse_px(s1_op.chan[c], cur_w[c] + carry[c], dot_threshold);
      base[c]   = pend_v[c] ? pend[c] : nxt_w[c];
      wval[c]   = (active[c] && !s1_op.flush) ? base[c] + px[c].e3 : base[c];
      dots[c]   = active[c] && px[c].on;
    end
  end

  assign wr_ctl.nxt_we   = fire;
  assign wr_ctl.clr_we   = fire && s1_op.flush;
  assign wr_ctl.cur_bank = s1_op.bank;
  assign wr_addr         = s1_pos;
  assign wr_data         = wval;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && issue) begin
      s1_op  <= op_in;
      s1_pos <= pos_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= '0;
      carry  <= '0;
    end else if (fire) begin
      if (s1_op.flush) begin
        pend_v <= '1;
        carry  <= '0;
      end else begin
        for (int c = 0; c < NUM_LANES; c++) begin
          if (sat) begin
            pend_v[c] <= 1'b1;
          end else begin
            pend_v[c] <= active[c];
          end
          if (active[c]) begin
            carry[c] <= px[c].e3;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      for (int c = 0; c < NUM_LANES; c++) begin
        if (s1_op.flush) begin
          pend[c] <= '0;
        end else if (sat) begin
          pend[c] <= wval[c];
        end else if (active[c]) begin
          pend[c] <= px[c].e2;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire && !s1_op.flush) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && !s1_op.flush) begin
      m_tdata <= {5'b00000, dots};
      m_tlast <= s1_op.last;
    end
  end

  `ASSERT_NEXT(a_flush_state, fire && s1_op.flush, pend_v == '1 && carry == '0,
               "row end left stale carry or next-row state")

endmodule

// ===== rtl/error_diffusion_dither_row.sv =====
// ----------------------------------------------------------------------------
// error_diffusion_dither_row
// Error-diffusion dither of one printer row, up to three ink channels.
// ----------------------------------------------------------------------------
// Each input transaction is one source pixel with a repeat count (0 counts as
// one, anything above MAX_REPEAT as MAX_REPEAT); it produces that many output
// transactions, one on/off dot per channel each, tlast on the final one. The
// sequencer accepts an item, then issues its dots, reading both line buffers
// for each, and after a row-end item issues a flush op for the bank swap; it
// takes no new item until the last one is fully issued, and backpressure on
// the output stalls the whole pipe. Errors live in two synchronous RAMs of
// MAX_ROW_PIXELS+1 words (three error bytes per column); a fill count per RAM
// makes columns never written since reset read as zero, so there is no
// clearing pass after reset. Configuration writes are to be made only while
// no transaction is in flight.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module error_diffusion_dither_row #(
  parameter int MAX_ROW_PIXELS = 4096,
  parameter int MAX_REPEAT     = 16
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  // source pixels
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] chan_yellow_or_grey, [15:8] chan_magenta, [23:16] chan_cyan,
  // [28:24] repeat_count, [31:29] zero
  input  logic [31:0] s_axis_tdata,
  input  logic        s_axis_tlast,  // row_end
  // dots
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] dot_yellow_or_black, [1] dot_magenta, [2] dot_cyan, [7:3] zero
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tlast   // last_of_run
);

  import edd_pkg::*;

  localparam int DEPTH = MAX_ROW_PIXELS + 1;
  localparam int PW    = $clog2(DEPTH);
  localparam int FW    = $clog2(DEPTH + 1);

  // configuration registers
  logic       colour_mode;
  logic [7:0] dot_threshold;

  // sequencer to update stage
  logic          issue;
  logic          adv;
  edd_op_t       op;
  logic [PW-1:0] pos;

  // update stage write-back
  edd_wr_ctl_t      wr_ctl;
  logic [PW-1:0]    wr_addr;
  logic [ERR_W-1:0] wr_data;

  // per-bank RAM ports; both banks are read at the same column
  logic             ram_we    [2];
  logic [PW-1:0]    ram_waddr [2];
  logic [ERR_W-1:0] ram_wdata [2];
  logic [ERR_W-1:0] ram_q     [2];
  logic [ERR_W-1:0] rd_eff    [2];
  logic             rd_zero   [2];
  logic [FW-1:0]    fill      [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      colour_mode   <= 1'b0;
      dot_threshold <= DOT_THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLOUR_MODE:   colour_mode   <= cfg_data[0];
        REG_DOT_THRESHOLD: dot_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  edd_seq #(
    .MAX_ROW_PIXELS (MAX_ROW_PIXELS),
    .MAX_REPEAT     (MAX_REPEAT)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_axis_tvalid),
    .s_tready    (s_axis_tready),
    .s_tdata     (s_axis_tdata),
    .s_tlast     (s_axis_tlast),
    .colour_mode (colour_mode),
    .adv         (adv),
    .issue       (issue),
    .op          (op),
    .pos         (pos)
  );

  // Bank b takes the column write when it is the next-row bank, and the
  // column-0 clear when it is the current-row bank; a flush does both, to
  // different banks, in the same cycle.
  always_comb begin
    for (int b = 0; b < 2; b++) begin
      if (wr_ctl.nxt_we && (wr_ctl.cur_bank != 1'(b))) begin
        ram_we[b]    = 1'b1;
        ram_waddr[b] = wr_addr;
        ram_wdata[b] = wr_data;
      end else begin
        ram_we[b]    = wr_ctl.clr_we && (wr_ctl.cur_bank == 1'(b));
        ram_waddr[b] = '0;
        ram_wdata[b] = '0;
      end
      rd_eff[b] = rd_zero[b] ? '0 : ram_q[b];
    end
  end

  edd_ram #(
    .WIDTH (ERR_W),
    .DEPTH (DEPTH)
  ) u_ram0 (
    .clk   (clk),
    .we    (ram_we[0]),
    .waddr (ram_waddr[0]),
    .wdata (ram_wdata[0]),
    .re    (issue),
    .raddr (pos),
    .rdata (ram_q[0])
  );

  edd_ram #(
    .WIDTH (ERR_W),
    .DEPTH (DEPTH)
  ) u_ram1 (
    .clk   (clk),
    .we    (ram_we[1]),
    .waddr (ram_waddr[1]),
    .wdata (ram_wdata[1]),
    .re    (issue),
    .raddr (pos),
    .rdata (ram_q[1])
  );

  // Writes to a bank always land at or just above its written prefix, so one
  // fill count per bank tells written columns from never-written ones. The
  // flag is taken with the read so it matches the data it qualifies.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill[0] <= '0;
      fill[1] <= '0;
    end else begin
      for (int b = 0; b < 2; b++) begin
        if (ram_we[b] && (FW'(ram_waddr[b]) >= fill[b])) begin
          fill[b] <= FW'(ram_waddr[b]) + FW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      for (int b = 0; b < 2; b++) begin
        rd_zero[b] <= FW'(pos) >= fill[b];
      end
    end
  end

  edd_diffuse #(
    .MAX_ROW_PIXELS (MAX_ROW_PIXELS)
  ) u_diffuse (
    .clk           (clk),
    .rst           (rst),
    .dot_threshold (dot_threshold),
    .issue         (issue),
    .op_in         (op),
    .pos_in        (pos),
    .rd0           (rd_eff[0]),
    .rd1           (rd_eff[1]),
    .adv           (adv),
    .wr_ctl        (wr_ctl),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .m_tvalid      (m_axis_tvalid),
    .m_tready      (m_axis_tready),
    .m_tdata       (m_axis_tdata),
    .m_tlast       (m_axis_tlast)
  );

  `ASSERT_IMPLIES(a_fill_bound, 1'b1,
                  fill[0] <= FW'(DEPTH) && fill[1] <= FW'(DEPTH),
                  "line buffer fill count ran past its depth")

endmodule
